// ===== rtl/ffa_pkg.sv =====
// Shared types, sizes and status codes of the first-fit allocator.
// Used by ffa_cell and first_fit_free_list_allocator_unit.
package ffa_pkg;

    localparam int HEAP_BYTES  = 65536;
    localparam int CHUNK_BYTES = 4096;
    localparam int FREE_SLOTS  = 16;
    localparam int TBL_DEPTH   = HEAP_BYTES / 16;
    localparam int IDX_W       = $clog2(FREE_SLOTS);
    localparam int CNT_W       = $clog2(FREE_SLOTS + 1);
    localparam int TBL_W       = $clog2(TBL_DEPTH);
    localparam int CHUNK_SH    = $clog2(CHUNK_BYTES);
    localparam int NEED_W      = 18;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_MEM    = 3'd2;
    localparam logic [2:0] ST_LIST_FULL = 3'd3;
    localparam logic [2:0] ST_NULL_FREE = 3'd4;

    typedef struct packed {
        logic [15:0] offset;
        logic [16:0] size;
    } t_node;

    typedef struct packed {
        logic push;
        logic pull;
        logic load;
    } t_cell_cmd;

endpackage

// ===== rtl/ffa_cell.sv =====
// One free-list entry of the allocator's shift chain.
// Depends on ffa_pkg.
module ffa_cell
    import ffa_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  t_node             i_left,
    input  t_node             i_right,
    input  t_node             i_load,
    input  logic [NEED_W-1:0] i_need,
    output t_node             o_node,
    output logic              o_fit
);

    t_node r_node;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_node <= i_left;
        end else if (i_cmd.pull) begin
            r_node <= i_right;
        end else if (i_cmd.load) begin
            r_node <= i_load;
        end
    end

    assign o_node = r_node;
    assign o_fit  = {1'b0, r_node.size} >= i_need;

endmodule

// ===== rtl/first_fit_free_list_allocator_unit.sv =====
// Top level of the first-fit free-list heap allocator.
// Depends on ffa_pkg and ffa_cell.
//
// A transfer is taken when start is high and busy is low; one result follows
// with o_done high for one cycle and cannot be stalled. The block size table
// is read at the accepting edge. A free, a zero-size request and an allocate
// refused for the first chunk end in the check state. Any other allocate passes
// the check state, with the first chunk pushed if the list is empty, and then
// the search state: one search over the cell chain with the list update, run
// again after the heap grows when the search misses. The next transfer may be
// taken in the result cycle.
module first_fit_free_list_allocator_unit
    import ffa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [16:0] i_request_size,
    input  logic [15:0] i_block_address,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_granted_address,
    output logic [16:0] o_granted_size
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [16:0]       r_heap_limit;
    logic [16:0]       r_heap_top, n_heap_top;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_op;
    logic              r_req_zero;
    logic [15:0]       r_addr;
    logic [NEED_W-1:0] r_need;
    logic [16:0]       r_tbl_rd;
    logic [16:0]       r_table [TBL_DEPTH];
    logic              r_done, n_done;
    logic [2:0]        r_status, n_status;
    logic [15:0]       r_gaddr, n_gaddr;
    logic [16:0]       r_gsize, n_gsize;

    logic              w_accept;
    logic [NEED_W-1:0] w_hdr, w_need;
    logic [16:0]       w_limit;
    logic [18:0]       w_total, w_chunk_end, w_grow_end;
    t_node             w_push, w_load;
    logic              w_do_push, w_do_pull, w_do_load;
    logic [IDX_W-1:0]  w_idx;
    logic              w_found;
    logic [FREE_SLOTS-1:0] w_fit, w_cell_fit;
    t_node             w_nodes [FREE_SLOTS];
    t_node             w_sel;
    logic [NEED_W-1:0] w_rem;
    logic [15:0]       w_uaddr;
    logic              w_tbl_we;
    logic [16:0]       w_tbl_wd;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    assign w_hdr  = {1'b0, i_request_size} + NEED_W'(8);
    assign w_need = (w_hdr < NEED_W'(32)) ? NEED_W'(32)
                                          : ((w_hdr + NEED_W'(15)) & ~NEED_W'(15));

    assign w_limit = (r_heap_limit > 17'(HEAP_BYTES)) ? 17'(HEAP_BYTES) : r_heap_limit;
    assign w_total = (19'(r_need >> CHUNK_SH) + 19'd1) << CHUNK_SH;
    assign w_chunk_end = {2'b0, r_heap_top} + 19'(CHUNK_BYTES);
    assign w_grow_end  = {2'b0, r_heap_top} + w_total;

    always_comb begin
        w_found = 1'b0;
        w_idx   = '0;
        for (int k = FREE_SLOTS - 1; k >= 0; k--) begin
            w_fit[k] = w_cell_fit[k] && (CNT_W'(k) < r_count);
            if (w_fit[k]) begin
                w_found = 1'b1;
                w_idx   = IDX_W'(k);
            end
        end
    end

    assign w_sel   = w_nodes[w_idx];
    assign w_rem   = {1'b0, w_sel.size} - r_need;
    assign w_uaddr = w_sel.offset + 16'd8;

    always_comb begin
        n_state    = r_state;
        n_heap_top = r_heap_top;
        n_count    = r_count;
        n_done     = 1'b0;
        n_status   = ST_OK;
        n_gaddr    = '0;
        n_gsize    = '0;
        w_do_push  = 1'b0;
        w_do_pull  = 1'b0;
        w_do_load  = 1'b0;
        w_push     = '0;
        w_load     = '0;
        w_tbl_we   = 1'b0;
        w_tbl_wd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (r_addr == 16'd0) begin
                        n_status = ST_NULL_FREE;
                    end else if (r_count >= CNT_W'(FREE_SLOTS)) begin
                        n_status = ST_LIST_FULL;
                    end else begin
                        w_do_push   = 1'b1;
                        w_push.offset = r_addr - 16'd8;
                        w_push.size   = r_tbl_rd;
                        n_count     = r_count + CNT_W'(1);
                    end
                end else if (r_req_zero) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_ZERO_SIZE;
                end else if (r_count == '0) begin
                    if (w_chunk_end > {2'b0, w_limit}) begin
                        n_state  = S_IDLE;
                        n_done   = 1'b1;
                        n_status = ST_NO_MEM;
                    end else begin
                        w_do_push     = 1'b1;
                        w_push.offset = r_heap_top[15:0] + 16'd8;
                        w_push.size   = 17'(CHUNK_BYTES - 8);
                        n_count       = r_count + CNT_W'(1);
                        n_heap_top    = w_chunk_end[16:0];
                        n_state       = S_SEARCH;
                    end
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_found) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_gaddr  = w_uaddr;
                    w_tbl_we = 1'b1;
                    if (w_rem < NEED_W'(32)) begin
                        w_do_pull = 1'b1;
                        n_count   = r_count - CNT_W'(1);
                        w_tbl_wd  = w_sel.size;
                    end else begin
                        w_do_load     = 1'b1;
                        w_load.offset = w_sel.offset + r_need[15:0];
                        w_load.size   = w_rem[16:0];
                        w_tbl_wd      = r_need[16:0];
                    end
                    n_gsize = w_tbl_wd;
                end else if (r_count >= CNT_W'(FREE_SLOTS)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_LIST_FULL;
                end else if (w_grow_end > {2'b0, w_limit}) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_NO_MEM;
                end else begin
                    w_do_push     = 1'b1;
                    w_push.offset = r_heap_top[15:0] + 16'd8;
                    w_push.size   = w_total[16:0] - 17'd8;
                    n_count       = r_count + CNT_W'(1);
                    n_heap_top    = w_grow_end[16:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    for (genvar k = 0; k < FREE_SLOTS; k++) begin : g_cell
        t_cell_cmd w_cmd;
        t_node     w_left, w_right;
        assign w_cmd = {w_do_push,
                        w_do_pull && (IDX_W'(k) >= w_idx),
                        w_do_load && (IDX_W'(k) == w_idx)};
        if (k == 0) begin : g_first
            assign w_left = w_push;
        end else begin : g_mid
            assign w_left = w_nodes[k-1];
        end
        if (k == FREE_SLOTS - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_nodes[k+1];
        end
        ffa_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_load  (w_load),
            .i_need  (r_need),
            .o_node  (w_nodes[k]),
            .o_fit   (w_cell_fit[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tbl_rd <= r_table[i_block_address[15:4]];
        end
        if (w_tbl_we) begin
            r_table[w_uaddr[15:4]] <= w_tbl_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_operation;
            r_req_zero <= (i_request_size == 17'd0);
            r_addr     <= i_block_address;
            r_need     <= w_need;
        end
        r_status <= n_status;
        r_gaddr  <= n_gaddr;
        r_gsize  <= n_gsize;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heap_limit <= 17'(HEAP_BYTES);
            r_heap_top   <= '0;
            r_count      <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_heap_top <= n_heap_top;
            r_count    <= n_count;
            r_done     <= n_done;
            if (i_cfg_we) begin
                r_heap_limit <= i_cfg_wdata;
            end
        end
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_granted_address = r_gaddr;
    assign o_granted_size    = r_gsize;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FREE_SLOTS))
        else $error("free count above slot count");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_done |-> (r_state == S_EXEC || r_state == S_SEARCH))
        else $error("result raised outside an operation");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_heap_top) != r_heap_top |-> r_heap_top <= 17'(HEAP_BYTES))
        else $error("heap top beyond heap size");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_granted_size == 17'd0))
        else $error("size granted on failed transfer");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for first_fit_free_list_allocator_unit.
// Depends on ffa_pkg and the allocator RTL; predicts every result from its own model of the heap.
module testbench;
    import ffa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam int   HDR      = 8;
    localparam int   MIN_BLK  = 32;

    typedef enum logic [1:0] {ADDR_FIXED, ADDR_POOL, ADDR_LAST} t_addr_src;

    typedef struct {
        logic        op;
        logic [16:0] req;
        logic [15:0] addr;
        t_addr_src   src;
        bit          jitter;
        bit          drain;
        int          gap;
    } t_req;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] addr;
        logic [16:0] size;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_operation = 1'b0;
    logic [16:0] i_request_size = '0;
    logic [15:0] i_block_address = '0;
    logic        i_cfg_we = 1'b0;
    logic [16:0] i_cfg_wdata = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [15:0] o_granted_address;
    logic [16:0] o_granted_size;

    first_fit_free_list_allocator_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_request_size(i_request_size),
        .i_block_address(i_block_address), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .o_done(o_done), .o_status(o_status),
        .o_granted_address(o_granted_address), .o_granted_size(o_granted_size)
    );

    always #5 i_clk = ~i_clk;

    // heap model
    int unsigned heap_limit_q = 65536;
    int unsigned node_off[FREE_SLOTS];
    int unsigned node_sz[FREE_SLOTS];
    int unsigned node_cnt = 0;
    int unsigned heap_top_q = 0;
    int unsigned size_tbl[TBL_DEPTH];

    t_req        pending_q[$];
    t_grant      grant_q[$];
    logic [15:0] live_addrs[$];
    logic [15:0] last_grant = '0;
    int          mismatches = 0;

    function automatic void push_node(int unsigned off, int unsigned sz);
        if (node_cnt >= FREE_SLOTS) return;
        for (int k = node_cnt; k > 0; k--) begin
            node_off[k] = node_off[k-1];
            node_sz[k]  = node_sz[k-1];
        end
        node_off[0] = off & 16'hFFFF;
        node_sz[0]  = sz & 17'h1FFFF;
        node_cnt++;
    endfunction

    function automatic t_grant heap_step(t_req r);
        t_grant      g;
        int unsigned need, lim, i, node, nsz, granted, ua, total;
        bit          hit;
        g = '{ST_OK, '0, '0};
        hit = 0;
        if (r.op == OP_FREE) begin
            if (r.addr == 0) g.status = ST_NULL_FREE;
            else if (node_cnt >= FREE_SLOTS) g.status = ST_LIST_FULL;
            else push_node((r.addr - HDR) & 16'hFFFF, size_tbl[r.addr >> 4]);
            return g;
        end
        if (r.req == 0) begin
            g.status = ST_ZERO_SIZE;
            return g;
        end
        need = r.req + HDR;
        need = (need < MIN_BLK) ? MIN_BLK : ((need + 15) & ~32'd15);
        lim = (heap_limit_q < HEAP_BYTES) ? heap_limit_q : HEAP_BYTES;
        if (node_cnt == 0) begin
            if (heap_top_q + CHUNK_BYTES > lim) begin
                g.status = ST_NO_MEM;
                return g;
            end
            push_node(heap_top_q + HDR, CHUNK_BYTES - HDR);
            heap_top_q += CHUNK_BYTES;
        end
        for (i = 0; i < node_cnt; i++) begin
            if (node_sz[i] >= need) begin
                hit = 1;
                break;
            end
        end
        if (!hit) begin
            if (node_cnt >= FREE_SLOTS) begin
                g.status = ST_LIST_FULL;
                return g;
            end
            total = (need / CHUNK_BYTES + 1) * CHUNK_BYTES;
            if (heap_top_q + total > lim) begin
                g.status = ST_NO_MEM;
                return g;
            end
            push_node(heap_top_q + HDR, total - HDR);
            heap_top_q += total;
            i = 0;
        end
        node = node_off[i];
        nsz  = node_sz[i];
        if (nsz - need < MIN_BLK) begin
            for (int k = i; k + 1 < node_cnt; k++) begin
                node_off[k] = node_off[k+1];
                node_sz[k]  = node_sz[k+1];
            end
            node_cnt--;
            granted = nsz;
        end else begin
            node_off[i] = (node + need) & 16'hFFFF;
            node_sz[i]  = (nsz - need) & 17'h1FFFF;
            granted = need;
        end
        ua = (node + HDR) & 16'hFFFF;
        size_tbl[ua >> 4] = granted & 17'h1FFFF;
        g.addr = 16'(ua);
        g.size = 17'(granted);
        return g;
    endfunction

    // driver
    t_req cur;
    bit   staged = 0, presented = 0;
    int   gap_left = 0;

    always @(posedge i_clk) begin
        bit     fire;
        t_grant g;
        int     p;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            fire = start && !busy;
            if (fire) begin
                g = heap_step(cur);
                grant_q.push_back(g);
                if (cur.op == OP_ALLOC && g.status == ST_OK) begin
                    live_addrs.push_back(g.addr);
                    last_grant = g.addr;
                end
                presented = 0;
            end
            if (!presented) begin
                if (!staged && pending_q.size() > 0) begin
                    cur = pending_q.pop_front();
                    gap_left = cur.gap;
                    staged = 1;
                end
                if (staged && gap_left == 0 && !(cur.drain && grant_q.size() > 0)) begin
                    if (cur.op == OP_FREE && cur.src != ADDR_FIXED) begin
                        if (cur.src == ADDR_LAST) begin
                            cur.addr = last_grant;
                        end else if (live_addrs.size() > 0) begin
                            p = $urandom_range(live_addrs.size() - 1);
                            cur.addr = live_addrs[p];
                            if ($urandom_range(3) != 0) live_addrs.delete(p);
                        end else begin
                            cur.addr = '0;
                        end
                        if (cur.jitter && cur.addr != 0) cur.addr[3:0] = 4'($urandom_range(15));
                    end
                    start           <= 1'b1;
                    i_operation     <= cur.op;
                    i_request_size  <= cur.req;
                    i_block_address <= cur.addr;
                    presented = 1;
                    staged = 0;
                end else begin
                    start <= 1'b0;
                    if (staged && gap_left > 0) gap_left--;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_grant e;
        if (i_rst_n && o_done) begin
            if (grant_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: status %0d", o_status);
            end else begin
                e = grant_q.pop_front();
                if (o_status !== e.status || o_granted_address !== e.addr
                        || o_granted_size !== e.size) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st %0d addr %h size %0d, got st %0d addr %h size %0d",
                                 e.status, e.addr, e.size, o_status, o_granted_address,
                                 o_granted_size);
                end
            end
        end
    end

    function automatic t_req mk(logic op, int unsigned req, logic [15:0] addr, t_addr_src src);
        t_req r;
        r.op = op;
        r.req = 17'(req);
        r.addr = addr;
        r.src = src;
        r.jitter = 0;
        r.drain = 0;
        r.gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(14);
        return r;
    endfunction

    function automatic t_req rand_req(int quiet);
        t_req        r;
        int unsigned sz;
        case ($urandom_range(19))
            0:       sz = 0;
            1:       sz = $urandom_range(65536, 4000);
            2, 3:    sz = $urandom_range(2000);
            default: sz = $urandom_range(200, 1);
        endcase
        if ($urandom_range(99) < 55) r = mk(OP_ALLOC, sz, '0, ADDR_FIXED);
        else if ($urandom_range(19) == 0) r = mk(OP_FREE, 0, '0, ADDR_FIXED);
        else begin
            r = mk(OP_FREE, $urandom_range(65536), '0, ADDR_POOL);
            r.jitter = ($urandom_range(7) == 0);
        end
        if (!r.op) r.addr = 16'($urandom);
        if (quiet) r.gap = 0;
        return r;
    endfunction

    task automatic wait_idle();
        wait (pending_q.size() == 0 && !staged && !presented && grant_q.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(int unsigned v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 17'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        heap_limit_q = v & 17'h1FFFF;
    endtask

    initial begin
        int unsigned limits[5] = '{131071, 8192, 0, 40960, 65536};
        t_req r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_limit(131071);
        pending_q.push_back(mk(OP_ALLOC, 1, '0, ADDR_FIXED));
        pending_q.push_back(mk(OP_ALLOC, 0, '0, ADDR_FIXED));
        pending_q.push_back(mk(OP_ALLOC, 24, '0, ADDR_FIXED));
        pending_q.push_back(mk(OP_ALLOC, 25, '0, ADDR_FIXED));
        pending_q.push_back(mk(OP_FREE, 0, '0, ADDR_FIXED));
        pending_q.push_back(mk(OP_FREE, 0, '0, ADDR_LAST));
        pending_q.push_back(mk(OP_FREE, 0, '0, ADDR_LAST));
        r = mk(OP_FREE, 0, '0, ADDR_LAST);
        r.jitter = 1;
        pending_q.push_back(r);
        pending_q.push_back(mk(OP_ALLOC, 4000, '0, ADDR_FIXED));
        pending_q.push_back(mk(OP_ALLOC, 65536, '0, ADDR_FIXED));
        pending_q.push_back(mk(OP_ALLOC, 65535, '0, ADDR_FIXED));
        pending_q.push_back(mk(OP_ALLOC, 8184, '0, ADDR_FIXED));
        for (int k = 0; k < 18; k++) pending_q.push_back(mk(OP_FREE, 0, '0, ADDR_LAST));
        pending_q.push_back(mk(OP_ALLOC, 30000, '0, ADDR_FIXED));
        wait_idle();
        foreach (limits[ph]) begin
            write_limit(limits[ph]);
            for (int k = 0; k < 300; k++) begin
                r = rand_req(ph == 1 && k < 60);
                r.drain = (k == 150);
                pending_q.push_back(r);
            end
            wait_idle();
        end
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ffa_pkg.sv
rtl/ffa_cell.sv
rtl/first_fit_free_list_allocator_unit.sv
sim/testbench.sv
